// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/ile_pkg.sv =====
// types, constants and helper functions of the indexed list engine
`default_nettype none

package ile_pkg;

   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int DATA_W      = 32;
   localparam int FUNC_W      = 4;
   localparam int INDEX_W     = 7;
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int AT_W        = ((INDEX_W > CNT_W) ? INDEX_W : CNT_W) + 1;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FRONT = 4'd0,
      FN_INS_END   = 4'd1,
      FN_INS_AT    = 4'd2,
      FN_DEL_FRONT = 4'd3,
      FN_DEL_END   = 4'd4,
      FN_DEL_AT    = 4'd5,
      FN_SEARCH    = 4'd6,
      FN_ROTL      = 4'd7,
      FN_ROTR      = 4'd8
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADIDX   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTL,
      CMD_ROTR
   } cell_op_type;

   // broadcast to every cell of the row
   typedef struct packed {
      cell_op_type               op;
      logic [IDX_W-1:0]          at;
      logic [CNT_W-1:0]          fill;
      logic signed [DATA_W-1:0]  value;
      logic signed [DATA_W-1:0]  head;
      logic signed [DATA_W-1:0]  tail;
   } cell_cmd_type;

   // lowest set bit of a match vector
   function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] vec);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = IDX_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ile_cell.sv =====
// one list entry: holds a value and picks its next value from its neighbours
`default_nettype none

module ile_cell (
   input  wire logic                                 clock,
   input  wire ile_pkg::cell_cmd_type                cmd,
   input  wire logic [ile_pkg::IDX_W-1:0]            cell_idx,
   input  wire logic signed [ile_pkg::DATA_W-1:0]    left_data,
   input  wire logic signed [ile_pkg::DATA_W-1:0]    right_data,
   input  wire logic signed [ile_pkg::DATA_W-1:0]    cmp_value,
   output logic signed [ile_pkg::DATA_W-1:0]         data,
   output logic                                      match,
   output logic [ile_pkg::DATA_W-1:0]                tail_part
);
   import ile_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic [CNT_W-1:0]         idx_ext;
   logic [CNT_W-1:0]         at_ext;
   logic                     in_use;
   logic                     is_last;

   assign idx_ext = CNT_W'(cell_idx);
   assign at_ext  = CNT_W'(cmd.at);
   assign in_use  = idx_ext < cmd.fill;
   assign is_last = (idx_ext + CNT_W'(1)) == cmd.fill;

   assign data      = data_ff;
   assign match     = in_use && (data_ff == cmp_value);
   assign tail_part = is_last ? data_ff : '0;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CMD_INSERT: begin
            if (idx_ext == at_ext) begin
               data_in = cmd.value;
            end else if (idx_ext > at_ext && idx_ext <= cmd.fill) begin
               data_in = left_data;
            end
         end
         CMD_DELETE: begin
            if (idx_ext >= at_ext && (idx_ext + CNT_W'(1)) < cmd.fill) begin
               data_in = right_data;
            end
         end
         CMD_ROTL: begin
            if ((idx_ext + CNT_W'(1)) < cmd.fill) begin
               data_in = right_data;
            end else if (is_last) begin
               data_in = cmd.head;
            end
         end
         CMD_ROTR: begin
            if (idx_ext == '0) begin
               data_in = cmd.tail;
            end else if (in_use) begin
               data_in = left_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_engine.sv =====
// top level of the indexed list engine: control, fill count and the row of cells
`default_nettype none
`include "assert_macros.svh"

// Indexed list engine. Holds a packed list of up to 64 signed 32-bit values in a row
// of cells, each cell one entry. A request transaction asks for an insert, delete,
// search or rotate; every request gives exactly one response transaction with a
// status, the position touched or found, and the count afterwards. Each request
// is handled in the idle and apply states: on acceptance every cell compares its
// value with the request value and the last entry is captured; in the apply state
// the status is resolved and all cells shift or load together in a single step.
// The response is registered as the apply step ends and waits in an output register.
// req_tready is low in the apply state, so no new request is taken before the held
// one is applied; the apply state stretches while the previous response is still
// held back by the receiver. Entries are not cleared at reset; only the count is.

module indexed_list_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // func [3:0], value [35:4], index [42:36], zero [47:43]
   input  wire logic [ile_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // status [2:0], position [8:3], count [15:9]
   output logic [ile_pkg::RSP_TDATA_W-1:0]           rsp_tdata
);
   import ile_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_APPLY
   } state_type;

   state_type                 state_ff;
   logic [FUNC_W-1:0]         func_ff;
   logic signed [DATA_W-1:0]  value_ff;
   logic [INDEX_W-1:0]        index_ff;
   logic [CAPACITY-1:0]       match_ff;
   logic [DATA_W-1:0]         tail_ff;
   logic [CNT_W-1:0]          fill_ff;
   logic [CNT_W-1:0]          fill_in;
   logic                      rsp_tvalid_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [COUNT_W-1:0]        count_ff;

   logic                      accept;
   logic                      apply;
   logic [FUNC_W-1:0]         req_func;
   logic signed [DATA_W-1:0]  req_value;
   logic [INDEX_W-1:0]        req_index;

   status_type                status_in;
   logic [IDX_W-1:0]          pos_in;
   logic [AT_W-1:0]           at;
   logic [AT_W-1:0]           fill_ext;
   cell_op_type               op_in;
   cell_cmd_type              cmd;

   logic signed [DATA_W-1:0]  cell_data  [CAPACITY];
   logic signed [DATA_W-1:0]  left_data  [CAPACITY];
   logic signed [DATA_W-1:0]  right_data [CAPACITY];
   logic [DATA_W-1:0]         tail_part  [CAPACITY];
   logic [CAPACITY-1:0]       match_vec;
   logic [DATA_W-1:0]         tail_or;

   assign req_func  = req_tdata[FUNC_W-1:0];
   assign req_value = req_tdata[FUNC_W+DATA_W-1:FUNC_W];
   assign req_index = req_tdata[FUNC_W+DATA_W+INDEX_W-1:FUNC_W+DATA_W];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign apply      = (state_ff == S_APPLY) && (!rsp_tvalid_ff || rsp_tready);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {count_ff, pos_ff, status_ff};

   assign fill_ext = AT_W'(fill_ff);

   // resolve status, position and the cell command for the held request
   always_comb begin
      status_in = ST_OK;
      pos_in    = '0;
      op_in     = CMD_HOLD;
      fill_in   = fill_ff;
      at        = '0;
      case (func_type'(func_ff))
         FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
            if (func_type'(func_ff) == FN_INS_END) begin
               at = fill_ext;
            end else if (func_type'(func_ff) == FN_INS_AT) begin
               at = AT_W'(index_ff);
            end
            if (fill_ff == CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else if (at > fill_ext) begin
               status_in = ST_BADIDX;
            end else begin
               pos_in  = at[IDX_W-1:0];
               op_in   = CMD_INSERT;
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
            if (func_type'(func_ff) == FN_DEL_END) begin
               at = fill_ext - AT_W'(1);
            end else if (func_type'(func_ff) == FN_DEL_AT) begin
               at = AT_W'(index_ff);
            end
            if (fill_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (at >= fill_ext) begin
               status_in = ST_BADIDX;
            end else begin
               pos_in  = at[IDX_W-1:0];
               op_in   = CMD_DELETE;
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         FN_SEARCH: begin
            if (|match_ff) begin
               pos_in = first_set(match_ff);
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         FN_ROTL: begin
            if (fill_ff > CNT_W'(1)) begin
               op_in = CMD_ROTL;
            end
         end
         FN_ROTR: begin
            if (fill_ff > CNT_W'(1)) begin
               op_in = CMD_ROTR;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      cmd.op    = apply ? op_in : CMD_HOLD;
      cmd.at    = pos_in;
      cmd.fill  = fill_ff;
      cmd.value = value_ff;
      cmd.head  = cell_data[0];
      cmd.tail  = tail_ff;
   end

   // neighbour links along the row, open at both ends
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_data[g] = '0;
      end else begin : g_inner_left
         assign left_data[g] = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_data[g] = '0;
      end else begin : g_inner_right
         assign right_data[g] = cell_data[g+1];
      end

      ile_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_idx   (IDX_W'(g)),
         .left_data  (left_data[g]),
         .right_data (right_data[g]),
         .cmp_value  (req_value),
         .data       (cell_data[g]),
         .match      (match_vec[g]),
         .tail_part  (tail_part[g])
      );
   end

   always_comb begin
      tail_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_or = tail_or | tail_part[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !apply) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               if (apply) begin
                  fill_ff       <= fill_in;
                  rsp_tvalid_ff <= 1'b1;
                  status_ff     <= status_in;
                  pos_ff        <= POS_W'(pos_in);
                  count_ff      <= COUNT_W'(fill_in);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         value_ff <= req_value;
         index_ff <= req_index;
         match_ff <= match_vec;
         tail_ff  <= tail_or;
      end
   end

   `ASSERT_IMPL(a_fill_cap, clock, reset, 1'b1, fill_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_fill_step, clock, reset, 1'b1, (fill_ff - $past(fill_ff) + 1'b1) <= 2'd2)
   `ASSERT_NEXT(a_stall, clock, reset, rsp_tvalid && !rsp_tready, $stable({rsp_tvalid, rsp_tdata}))
   `ASSERT_IMPL(a_fill_moves_on_apply, clock, reset, !apply, cmd.op == CMD_HOLD)

endmodule

`default_nettype wire
